[hdl/lipl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_pkg
// Shared constants, register map, configuration and control types for the
// piecewise-linear position lookup.
// ----------------------------------------------------------------------------
package lipl_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W    = 9;
  localparam int KEY_BITS     = 64;
  localparam int KEY_W        = 64;
  localparam int COEF_W       = 64;
  localparam int POS_W        = 32;
  localparam int ERR_W        = 32;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  // prediction is signed Q96.32, window bounds keep the integer part
  localparam int PRED_W = 128;
  localparam int BND_W  = PRED_W - 32;
  // error margin scaled to 2^33 fits 49 bits, plus the rounding term
  localparam int E_W    = 50;
  localparam logic [E_W-1:0] RND_Q32 = E_W'((64'd1 << 32) - 64'd1);
  localparam logic [E_W-1:0] RND_Q33 = E_W'((64'd1 << 33) - 64'd1);

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_MIN_KEY       = 3'd0,
    REG_MAX_KEY       = 3'd1,
    REG_ENTRY_COUNT   = 3'd2,
    REG_ERROR_BOUND   = 3'd3,
    REG_LEVEL_MODE    = 3'd4,
    REG_SEGMENT_COUNT = 3'd5
  } reg_idx_t;

  localparam logic [POS_W-1:0]     RST_ENTRY_COUNT   = 32'd1;
  localparam logic [ERR_W-1:0]     RST_ERROR_BOUND   = 32'd524288;
  localparam logic [SEG_CNT_W-1:0] RST_SEGMENT_COUNT = 9'd2;

  typedef struct packed {
    logic [KEY_W-1:0]     min_key;
    logic [KEY_W-1:0]     max_key;
    logic [POS_W-1:0]     entry_count;
    logic [ERR_W-1:0]     error_bound;
    logic                 level_mode;
    logic [SEG_CNT_W-1:0] segment_count;
  } cfg_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_MISS = 2'd1,
    RES_CALC = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    logic      write_seg;
    logic      search_init;
    logic      probe;
    logic      coef_load;
    logic      mul_go;
    logic [1:0] mul_sel;
    logic      predict;
    logic      round;
    logic      res_write;
    res_kind_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic out_of_range;
    logic search_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hdl/lipl_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_in_if
// Input item channel: lookup key or one segment load.
// ----------------------------------------------------------------------------
interface lipl_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [lipl_pkg::KEY_W-1:0]          key;
  logic [lipl_pkg::SEG_IDX_W-1:0]      seg_index;
  logic [lipl_pkg::KEY_W-1:0]          seg_start;
  logic signed [lipl_pkg::COEF_W-1:0]  seg_slope;
  logic signed [lipl_pkg::COEF_W-1:0]  seg_intercept;

  modport source (
    output valid, mode, key, seg_index, seg_start, seg_slope, seg_intercept,
    input  ready
  );
  modport sink (
    input  valid, mode, key, seg_index, seg_start, seg_slope, seg_intercept,
    output ready
  );
endinterface
`default_nettype wire

[hdl/lipl_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_out_if
// Result channel: candidate position window and miss flag.
// ----------------------------------------------------------------------------
interface lipl_out_if;
  logic                         valid;
  logic                         ready;
  logic [lipl_pkg::POS_W-1:0]   lower_pos;
  logic [lipl_pkg::POS_W-1:0]   upper_pos;
  logic                         miss;

  modport source (
    output valid, lower_pos, upper_pos, miss,
    input  ready
  );
  modport sink (
    input  valid, lower_pos, upper_pos, miss,
    output ready
  );
endinterface
`default_nettype wire

[hdl/lipl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lipl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/lipl_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_regs
// APB-style configuration registers, 64-bit data, registers at 8-byte steps.
// ----------------------------------------------------------------------------
module lipl_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lipl_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lipl_pkg::CFG_DATA_W-1:0]     pwdata,
  output      logic [lipl_pkg::CFG_DATA_W-1:0]     prdata,
  output      logic                                pready,
  output      lipl_pkg::cfg_t                      cfg
);

  lipl_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = lipl_pkg::reg_idx_t'(paddr[lipl_pkg::CFG_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_key       <= '0;
      cfg.max_key       <= '0;
      cfg.entry_count   <= lipl_pkg::RST_ENTRY_COUNT;
      cfg.error_bound   <= lipl_pkg::RST_ERROR_BOUND;
      cfg.level_mode    <= 1'b0;
      cfg.segment_count <= lipl_pkg::RST_SEGMENT_COUNT;
    end else if (wr_en) begin
      unique case (idx)
        lipl_pkg::REG_MIN_KEY:       cfg.min_key       <= pwdata;
        lipl_pkg::REG_MAX_KEY:       cfg.max_key       <= pwdata;
        lipl_pkg::REG_ENTRY_COUNT:   cfg.entry_count   <= pwdata[lipl_pkg::POS_W-1:0];
        lipl_pkg::REG_ERROR_BOUND:   cfg.error_bound   <= pwdata[lipl_pkg::ERR_W-1:0];
        lipl_pkg::REG_LEVEL_MODE:    cfg.level_mode    <= pwdata[0];
        lipl_pkg::REG_SEGMENT_COUNT: cfg.segment_count <= pwdata[lipl_pkg::SEG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lipl_pkg::REG_MIN_KEY:       prdata = cfg.min_key;
      lipl_pkg::REG_MAX_KEY:       prdata = cfg.max_key;
      lipl_pkg::REG_ENTRY_COUNT:   prdata = lipl_pkg::CFG_DATA_W'(cfg.entry_count);
      lipl_pkg::REG_ERROR_BOUND:   prdata = lipl_pkg::CFG_DATA_W'(cfg.error_bound);
      lipl_pkg::REG_LEVEL_MODE:    prdata = lipl_pkg::CFG_DATA_W'(cfg.level_mode);
      lipl_pkg::REG_SEGMENT_COUNT: prdata = lipl_pkg::CFG_DATA_W'(cfg.segment_count);
      default:                     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/lipl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_ctrl
// Sequencer: dispatch, binary search probes, partial-product multiply,
// rounding and result write.
// ----------------------------------------------------------------------------
module lipl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire lipl_pkg::status_t status,
  output      lipl_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_COEF,
    ST_MUL,
    ST_DRAIN,
    ST_PRED,
    ST_ROUND,
    ST_RESULT
  } state_t;

  state_t                state;
  logic [1:0]            mul_cnt;
  lipl_pkg::res_kind_t   res_kind;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mul_cnt  <= '0;
      res_kind <= lipl_pkg::RES_ZERO;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          if (status.is_load) begin
            res_kind <= lipl_pkg::RES_ZERO;
            state    <= ST_RESULT;
          end else if (status.out_of_range) begin
            res_kind <= lipl_pkg::RES_MISS;
            state    <= ST_RESULT;
          end else begin
            res_kind <= lipl_pkg::RES_CALC;
            state    <= ST_PROBE_RD;
          end
        end
        ST_PROBE_RD: begin
          state <= status.search_done ? ST_COEF : ST_PROBE_CMP;
        end
        ST_PROBE_CMP: state <= ST_PROBE_RD;
        ST_COEF: begin
          mul_cnt <= '0;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          mul_cnt <= mul_cnt + 2'd1;
          if (mul_cnt == 2'd3) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_PRED;
        ST_PRED:  state <= ST_ROUND;
        ST_ROUND: state <= ST_RESULT;
        ST_RESULT: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.res_sel     = res_kind;
    cmd.mul_sel     = mul_cnt;
    cmd.capture     = (state == ST_IDLE) && in_valid;
    cmd.write_seg   = (state == ST_DISPATCH) && status.is_load;
    cmd.search_init = (state == ST_DISPATCH) && !status.is_load && !status.out_of_range;
    cmd.probe       = (state == ST_PROBE_CMP);
    cmd.coef_load   = (state == ST_COEF);
    cmd.mul_go      = (state == ST_MUL);
    cmd.predict     = (state == ST_PRED);
    cmd.round       = (state == ST_ROUND);
    cmd.res_write   = (state == ST_RESULT) && status.out_free;
  end

endmodule
`default_nettype wire

[hdl/lipl_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lipl_dp
// Datapath: segment tables, search bounds, 32x32 multiplier with 128-bit
// accumulator, window rounding and the result register.
// ----------------------------------------------------------------------------
module lipl_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire lipl_pkg::cfg_t                       cfg,
  input  wire lipl_pkg::cmd_t                       cmd,
  output      lipl_pkg::status_t                    status,
  input  wire logic                                 in_mode,
  input  wire logic [lipl_pkg::KEY_W-1:0]           in_key,
  input  wire logic [lipl_pkg::SEG_IDX_W-1:0]       in_seg_index,
  input  wire logic [lipl_pkg::KEY_W-1:0]           in_seg_start,
  input  wire logic [lipl_pkg::COEF_W-1:0]          in_seg_slope,
  input  wire logic [lipl_pkg::COEF_W-1:0]          in_seg_intercept,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic [lipl_pkg::POS_W-1:0]           out_lower,
  output      logic [lipl_pkg::POS_W-1:0]           out_upper,
  output      logic                                 out_miss
);

  localparam int IW  = lipl_pkg::SEG_IDX_W;
  localparam int KW  = lipl_pkg::KEY_W;
  localparam int CW  = lipl_pkg::COEF_W;
  localparam int PW  = lipl_pkg::PRED_W;
  localparam int BW  = lipl_pkg::BND_W;
  localparam int EW  = lipl_pkg::E_W;
  localparam int NW  = lipl_pkg::POS_W;
  localparam int HW  = KW / 2;

  // captured item
  logic          mode_r;
  logic [KW-1:0] key_r;
  logic [IW-1:0] idx_r;
  logic [KW-1:0] start_r;
  logic [CW-1:0] slope_r;
  logic [CW-1:0] icpt_r;

  // search
  logic [IW-1:0] left;
  logic [IW-1:0] right;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] n_m1;

  // tables
  logic                 tbl_we;
  logic [KW-1:0]        start_q;
  logic [2*CW-1:0]      coef_q;

  // arithmetic
  logic          neg_r;
  logic [CW-1:0] mag_r;
  logic [CW-1:0] icpt_q_r;
  logic [2*HW-1:0] prod_r;
  logic [1:0]    prod_sh_r;
  logic          prod_vld_r;
  logic [PW-1:0] prod_ext;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] x_r;
  logic [EW-1:0] e_r;
  logic [EW-1:0] e_up_r;
  logic          lvl_r;
  logic [PW:0]   lx;
  logic [PW-1:0] ux;
  logic [BW-1:0] lq_r;
  logic [BW-1:0] uq_r;
  logic [HW-1:0] mul_a;
  logic [HW-1:0] mul_b;

  // result
  logic          lq_neg;
  logic          uq_neg;
  logic          lower_miss;
  logic [NW-1:0] lower_v;
  logic [NW-1:0] upper_v;

  // ---------------------------------------------------------------- capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      key_r   <= in_key & lipl_pkg::KEY_MASK;
      idx_r   <= in_seg_index;
      start_r <= in_seg_start & lipl_pkg::KEY_MASK;
      slope_r <= in_seg_slope;
      icpt_r  <= in_seg_intercept;
    end
  end

  // ---------------------------------------------------------------- tables
  assign tbl_we = cmd.write_seg &&
                  ({1'b0, idx_r} < (IW+1)'(lipl_pkg::MAX_SEGMENTS));

  lipl_ram #(.WIDTH(KW), .DEPTH(lipl_pkg::MAX_SEGMENTS)) u_start_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx_r),
    .wdata (start_r),
    .raddr (mid),
    .rdata (start_q)
  );

  lipl_ram #(.WIDTH(2*CW), .DEPTH(lipl_pkg::MAX_SEGMENTS)) u_coef_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx_r),
    .wdata ({slope_r, icpt_r}),
    .raddr (left),
    .rdata (coef_q)
  );

  // ---------------------------------------------------------------- search
  always_comb begin
    if (cfg.segment_count < lipl_pkg::SEG_CNT_W'(2)) begin
      n_m1 = IW'(1);
    end else if (cfg.segment_count > lipl_pkg::SEG_CNT_W'(lipl_pkg::MAX_SEGMENTS)) begin
      n_m1 = IW'(lipl_pkg::MAX_SEGMENTS - 1);
    end else begin
      n_m1 = IW'(cfg.segment_count - lipl_pkg::SEG_CNT_W'(1));
    end
  end

  assign mid_sum = {1'b0, left} + {1'b0, right};
  assign mid     = mid_sum[IW:1];

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      left  <= '0;
      right <= n_m1;
    end else if (cmd.probe) begin
      if (key_r < start_q) right <= mid;
      else                 left  <= mid;
    end
  end

  // ------------------------------------------------------------- multiply
  assign mul_a = cmd.mul_sel[1] ? key_r[KW-1:HW] : key_r[HW-1:0];
  assign mul_b = cmd.mul_sel[0] ? mag_r[CW-1:HW] : mag_r[HW-1:0];

  always_comb begin
    case (prod_sh_r)
      2'd0:    prod_ext = {{(PW-2*HW){1'b0}}, prod_r};
      2'd1:    prod_ext = {{(PW-3*HW){1'b0}}, prod_r, {HW{1'b0}}};
      default: prod_ext = {prod_r, {(PW-2*HW){1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_load) begin
      neg_r    <= coef_q[2*CW-1];
      mag_r    <= coef_q[2*CW-1] ? (~coef_q[2*CW-1:CW] + CW'(1)) : coef_q[2*CW-1:CW];
      icpt_q_r <= coef_q[CW-1:0];
      acc_r    <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_ext;
    end
    if (cmd.mul_go) begin
      prod_r    <= mul_a * mul_b;
      prod_sh_r <= {1'b0, cmd.mul_sel[1]} + {1'b0, cmd.mul_sel[0]};
    end
    // apply sign and intercept in one add, carry-in completes the negate
    if (cmd.predict) begin
      x_r <= (neg_r ? ~acc_r : acc_r) + {{(PW-CW){icpt_q_r[CW-1]}}, icpt_q_r}
             + {{(PW-1){1'b0}}, neg_r};
    end
  end

  // ------------------------------------------------------------- rounding
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lvl_r <= cfg.level_mode;
      if (cfg.level_mode) begin
        e_r    <= {1'b0, cfg.error_bound, 17'd0};
        e_up_r <= {1'b0, cfg.error_bound, 17'd0} + lipl_pkg::RND_Q33;
      end else begin
        e_r    <= {2'd0, cfg.error_bound, 16'd0};
        e_up_r <= {2'd0, cfg.error_bound, 16'd0} + lipl_pkg::RND_Q32;
      end
    end
  end

  // floor((x - e) / 2^s) and ceil((x + e) / 2^s); x - e can drop below the
  // 128-bit range, so carry one extra sign bit on the lower side
  assign lx = {x_r[PW-1], x_r} - {{(PW+1-EW){1'b0}}, e_r};
  assign ux = x_r + {{(PW-EW){1'b0}}, e_up_r};

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      lq_r <= lvl_r ? lx[PW:33] : {lx[PW], lx[PW-2:32]};
      uq_r <= lvl_r ? {ux[PW-1], ux[PW-1:33]} : ux[PW-1:32];
    end
  end

  // --------------------------------------------------------------- result
  assign lq_neg     = lq_r[BW-1];
  assign uq_neg     = uq_r[BW-1];
  assign lower_miss = !lq_neg &&
                      ((lq_r[BW-1:NW] != '0) || (lq_r[NW-1:0] >= cfg.entry_count));
  assign lower_v    = lq_neg ? '0 : lq_r[NW-1:0];

  always_comb begin
    if (uq_neg) begin
      upper_v = '0;
    end else if ((uq_r[BW-1:NW] != '0) || (uq_r[NW-1:0] >= cfg.entry_count)) begin
      upper_v = cfg.entry_count - NW'(1);
    end else begin
      upper_v = uq_r[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      case (cmd.res_sel)
        lipl_pkg::RES_MISS: begin
          out_lower <= cfg.entry_count;
          out_upper <= cfg.entry_count;
          out_miss  <= 1'b1;
        end
        lipl_pkg::RES_CALC: begin
          out_lower <= lower_miss ? cfg.entry_count : lower_v;
          out_upper <= lower_miss ? cfg.entry_count : upper_v;
          out_miss  <= lower_miss;
        end
        default: begin
          out_lower <= '0;
          out_upper <= '0;
          out_miss  <= 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- status
  assign status.is_load      = mode_r;
  assign status.out_of_range = (key_r > cfg.max_key) || (key_r < cfg.min_key);
  assign status.search_done  = ((left + IW'(1)) == right);
  assign status.out_free     = !out_valid || out_ready;

endmodule
`default_nettype wire

[hdl/learned_index_position_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// learned_index_position_lookup
// Piecewise-linear learned-index lookup: segment table, binary search,
// linear prediction and error window, with an APB-style register port.
// ----------------------------------------------------------------------------
// Lookup: dispatch, P search probes (up to 8 with 256 segments, each one
//   start-key RAM read), multiply, prediction, rounding and result write.
// Load and out-of-range items go from dispatch to the result. The multiply
//   runs on one 32x32 unit. One item in flight; the next can be taken once
//   its result is in the output register, which may still wait to be taken.
// Reset (rst, synchronous) restores register defaults and idles the control;
//   segment tables are not cleared and hold nothing until loaded.
module learned_index_position_lookup (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lipl_in_if.sink                               item,
  lipl_out_if.source                            result,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lipl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [lipl_pkg::CFG_DATA_W-1:0]  pwdata,
  output      logic [lipl_pkg::CFG_DATA_W-1:0]  prdata,
  output      logic                             pready
);

  lipl_pkg::cfg_t    cfg;
  lipl_pkg::cmd_t    cmd;
  lipl_pkg::status_t status;
  logic              in_ready;

  assign item.ready = in_ready;

  lipl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lipl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lipl_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_mode          (item.mode),
    .in_key           (item.key),
    .in_seg_index     (item.seg_index),
    .in_seg_start     (item.seg_start),
    .in_seg_slope     (item.seg_slope),
    .in_seg_intercept (item.seg_intercept),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_lower        (result.lower_pos),
    .out_upper        (result.upper_pos),
    .out_miss         (result.miss)
  );

  // one item in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("input accepted while an item is in flight");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_write |-> (!result.valid || result.ready))
    else $error("result register overwritten");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.lower_pos <= result.upper_pos))
    else $error("lower bound above upper bound");

  a_miss_bounds: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.miss) |-> (result.lower_pos == result.upper_pos))
    else $error("miss with unequal bounds");

endmodule
`default_nettype wire
